### sv/bthm_pkg.sv
// shared types and constants for the branch target hit merge table
`default_nettype none
package bthm_pkg;

   localparam int TABLE_SLOTS = 1024;

   localparam int KIND_W   = 2;
   localparam int KEY_W    = 64;
   localparam int ADDR_W   = 64;
   localparam int STACK_W  = 5;
   localparam int COUNT_W  = 32;
   localparam int SLOT_W   = 10;
   localparam int STATUS_W = 3;

   localparam logic [KIND_W-1:0] KIND_MERGE = 2'd0;
   localparam logic [KIND_W-1:0] KIND_READ  = 2'd1;
   localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd2;

   localparam logic [STATUS_W-1:0] STATUS_ACCUM   = 3'd0;
   localparam logic [STATUS_W-1:0] STATUS_INSERT  = 3'd1;
   localparam logic [STATUS_W-1:0] STATUS_DROPPED = 3'd2;
   localparam logic [STATUS_W-1:0] STATUS_IGNORED = 3'd3;
   localparam logic [STATUS_W-1:0] STATUS_DONE    = 3'd4;

   typedef struct packed {
      logic [KEY_W-1:0]   key;
      logic [ADDR_W-1:0]  source;
      logic [STACK_W-1:0] stack;
      logic [ADDR_W-1:0]  site;
      logic [COUNT_W-1:0] count;
   } entry_type;

   typedef struct packed {
      logic [KEY_W-1:0]   item_key;
      logic [KEY_W-1:0]   slot_key;
      logic [COUNT_W-1:0] slot_count;
      logic [COUNT_W-1:0] hits;
   } match_req_type;

   typedef struct packed {
      logic               hit;
      logic [COUNT_W-1:0] sum;
   } match_rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_RD_WAIT,
      ST_ACCUM,
      ST_INSERT,
      ST_BLANK
   } state_type;

endpackage
`default_nettype wire

### sv/bthm_table_ram.sv
// slot table memory, one write port and one registered read port
`default_nettype none
module bthm_table_ram #(
   parameter int TABLE_SLOTS = bthm_pkg::TABLE_SLOTS,
   localparam int IDX_W = $clog2(TABLE_SLOTS)
) (
   input  wire logic                clock,
   input  wire logic                rd_en,
   input  wire logic [IDX_W-1:0]    rd_addr,
   output bthm_pkg::entry_type      rd_data,
   input  wire logic                wr_en,
   input  wire logic [IDX_W-1:0]    wr_addr,
   input  wire bthm_pkg::entry_type wr_data
);

   bthm_pkg::entry_type mem [TABLE_SLOTS];
   bthm_pkg::entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

### sv/bthm_match_unit.sv
// shared key compare and hit count adder
`default_nettype none
module bthm_match_unit (
   input  wire bthm_pkg::match_req_type mt_req,
   output bthm_pkg::match_rsp_type      mt_rsp
);

   always_comb begin
      mt_rsp.hit = (mt_req.item_key == mt_req.slot_key);
      mt_rsp.sum = mt_req.slot_count + mt_req.hits;
   end

endmodule
`default_nettype wire

### sv/bthm_sequencer.sv
// transaction sequencer: slot search, insert, accumulate, read and clear
`default_nettype none
module bthm_sequencer #(
   parameter int TABLE_SLOTS = bthm_pkg::TABLE_SLOTS,
   localparam int IDX_W = $clog2(TABLE_SLOTS),
   localparam int CNT_W = $clog2(TABLE_SLOTS + 1),
   localparam int CMP_W = (CNT_W > bthm_pkg::SLOT_W) ? CNT_W : bthm_pkg::SLOT_W
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_ready,
   input  wire logic [bthm_pkg::KIND_W-1:0]     req_kind,
   input  wire logic [bthm_pkg::KEY_W-1:0]      req_target_key,
   input  wire logic [bthm_pkg::ADDR_W-1:0]     req_source_addr,
   input  wire logic [bthm_pkg::STACK_W-1:0]    req_stack_index,
   input  wire logic [bthm_pkg::ADDR_W-1:0]     req_site_addr,
   input  wire logic [bthm_pkg::COUNT_W-1:0]    req_hit_count,
   input  wire logic [bthm_pkg::SLOT_W-1:0]     req_read_slot,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_ready,
   output logic [bthm_pkg::STATUS_W-1:0]        rsp_status,
   output logic [bthm_pkg::SLOT_W-1:0]          rsp_slot,
   output bthm_pkg::entry_type                  rsp_entry,
   output logic                                 ram_rd_en,
   output logic [IDX_W-1:0]                     ram_rd_addr,
   input  wire bthm_pkg::entry_type             ram_rd_data,
   output logic                                 ram_wr_en,
   output logic [IDX_W-1:0]                     ram_wr_addr,
   output bthm_pkg::entry_type                  ram_wr_data,
   output bthm_pkg::match_req_type              mt_req,
   input  wire bthm_pkg::match_rsp_type         mt_rsp
);

   bthm_pkg::state_type state_ff, state_in;
   logic [CNT_W-1:0] fill_ff, fill_in;
   logic [CNT_W-1:0] idx_ff, idx_in;
   logic [IDX_W-1:0] cmp_idx_ff, cmp_idx_in;
   logic cmp_valid_ff, cmp_valid_in;
   logic [bthm_pkg::STATUS_W-1:0] blank_status_ff, blank_status_in;

   logic clear_ff;
   logic [bthm_pkg::KEY_W-1:0]   key_ff;
   logic [bthm_pkg::ADDR_W-1:0]  source_ff;
   logic [bthm_pkg::STACK_W-1:0] stack_ff;
   logic [bthm_pkg::ADDR_W-1:0]  site_ff;
   logic [bthm_pkg::COUNT_W-1:0] hits_ff;
   logic [bthm_pkg::SLOT_W-1:0]  read_slot_ff;

   logic rsp_valid_ff, rsp_valid_in;
   logic [bthm_pkg::STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [bthm_pkg::SLOT_W-1:0] rsp_slot_ff, rsp_slot_in;
   bthm_pkg::entry_type rsp_entry_ff, rsp_entry_in;

   logic accept;
   logic out_free;
   logic load;
   bthm_pkg::entry_type ent;

   assign accept   = req_valid && req_ready;
   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      mt_req.item_key   = key_ff;
      mt_req.slot_key   = ram_rd_data.key;
      mt_req.slot_count = ram_rd_data.count;
      mt_req.hits       = hits_ff;
   end

   always_comb begin
      state_in        = state_ff;
      fill_in         = fill_ff;
      idx_in          = idx_ff;
      cmp_idx_in      = cmp_idx_ff;
      cmp_valid_in    = cmp_valid_ff;
      blank_status_in = blank_status_ff;
      req_ready       = 1'b0;
      load            = 1'b0;
      rsp_status_in   = rsp_status_ff;
      rsp_slot_in     = rsp_slot_ff;
      rsp_entry_in    = rsp_entry_ff;
      ram_rd_en       = 1'b0;
      ram_rd_addr     = idx_ff[IDX_W-1:0];
      ram_wr_en       = 1'b0;
      ram_wr_addr     = cmp_idx_ff;
      ent             = ram_rd_data;
      ent.count       = mt_rsp.sum;
      ram_wr_data     = ent;

      unique case (state_ff)
         bthm_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               case (req_kind)
                  bthm_pkg::KIND_MERGE: begin
                     if (req_target_key == '0) begin
                        blank_status_in = bthm_pkg::STATUS_IGNORED;
                        state_in        = bthm_pkg::ST_BLANK;
                     end else begin
                        idx_in       = '0;
                        cmp_valid_in = 1'b0;
                        state_in     = bthm_pkg::ST_SEARCH;
                     end
                  end
                  bthm_pkg::KIND_READ: begin
                     ram_rd_en   = 1'b1;
                     ram_rd_addr = IDX_W'(req_read_slot);
                     state_in    = bthm_pkg::ST_RD_WAIT;
                  end
                  default: begin
                     blank_status_in = bthm_pkg::STATUS_DONE;
                     state_in        = bthm_pkg::ST_BLANK;
                  end
               endcase
            end
         end
         bthm_pkg::ST_SEARCH: begin
            if (cmp_valid_ff && mt_rsp.hit) begin
               state_in = bthm_pkg::ST_ACCUM;
            end else if (idx_ff != fill_ff) begin
               ram_rd_en    = 1'b1;
               cmp_idx_in   = idx_ff[IDX_W-1:0];
               cmp_valid_in = 1'b1;
               idx_in       = idx_ff + 1'b1;
            end else if (cmp_valid_ff) begin
               cmp_valid_in = 1'b0;
            end else if (fill_ff == CNT_W'(TABLE_SLOTS)) begin
               blank_status_in = bthm_pkg::STATUS_DROPPED;
               state_in        = bthm_pkg::ST_BLANK;
            end else begin
               state_in = bthm_pkg::ST_INSERT;
            end
         end
         bthm_pkg::ST_ACCUM: begin
            if (out_free) begin
               ram_wr_en     = 1'b1;
               load          = 1'b1;
               rsp_status_in = bthm_pkg::STATUS_ACCUM;
               rsp_slot_in   = bthm_pkg::SLOT_W'(cmp_idx_ff);
               rsp_entry_in  = ent;
               state_in      = bthm_pkg::ST_IDLE;
            end
         end
         bthm_pkg::ST_INSERT: begin
            ent.key    = key_ff;
            ent.source = source_ff;
            ent.stack  = stack_ff;
            ent.site   = site_ff;
            ent.count  = hits_ff;
            ram_wr_data = ent;
            ram_wr_addr = fill_ff[IDX_W-1:0];
            if (out_free) begin
               ram_wr_en     = 1'b1;
               load          = 1'b1;
               rsp_status_in = bthm_pkg::STATUS_INSERT;
               rsp_slot_in   = bthm_pkg::SLOT_W'(fill_ff);
               rsp_entry_in  = ent;
               fill_in       = fill_ff + 1'b1;
               state_in      = bthm_pkg::ST_IDLE;
            end
         end
         bthm_pkg::ST_RD_WAIT: begin
            if (out_free) begin
               load          = 1'b1;
               rsp_status_in = bthm_pkg::STATUS_DONE;
               rsp_slot_in   = read_slot_ff;
               if (CMP_W'(read_slot_ff) < CMP_W'(fill_ff)) begin
                  rsp_entry_in = ram_rd_data;
               end else begin
                  rsp_entry_in = '0;
               end
               state_in = bthm_pkg::ST_IDLE;
            end
         end
         bthm_pkg::ST_BLANK: begin
            if (out_free) begin
               load          = 1'b1;
               rsp_status_in = blank_status_ff;
               rsp_slot_in   = '0;
               rsp_entry_in  = '0;
               if (clear_ff) begin
                  fill_in = '0;
               end
               state_in = bthm_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = bthm_pkg::ST_IDLE;
         end
      endcase

      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bthm_pkg::ST_IDLE;
         fill_ff      <= '0;
         cmp_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         cmp_valid_ff <= cmp_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff          <= idx_in;
      cmp_idx_ff      <= cmp_idx_in;
      blank_status_ff <= blank_status_in;
      rsp_status_ff   <= rsp_status_in;
      rsp_slot_ff     <= rsp_slot_in;
      rsp_entry_ff    <= rsp_entry_in;
      if (accept) begin
         clear_ff     <= (req_kind == bthm_pkg::KIND_CLEAR);
         key_ff       <= req_target_key;
         source_ff    <= req_source_addr;
         stack_ff     <= req_stack_index;
         site_ff      <= req_site_addr;
         hits_ff      <= req_hit_count;
         read_slot_ff <= req_read_slot;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_slot   = rsp_slot_ff;
   assign rsp_entry  = rsp_entry_ff;

endmodule
`default_nettype wire

### sv/branch_target_hit_merge_table_top.sv
// top level of the branch target hit merge table
//
// A table of TABLE_SLOTS slots, each keyed by a nonzero branch target address and
// holding source address, stack index, site address and a 32-bit hit count. One
// transaction is worked on at a time and req_ready is high only while the block is
// idle; a finished result may still wait in the output register while the next
// transaction is taken. A merge scans the occupied slots through the single read
// port of the table memory, one slot per cycle, with one shared compare and adder;
// on a key match it adds the hit count into that slot, and when the key is not
// found it inserts the item in the first free slot, or drops it on a full table.
// Occupied slots always form a prefix tracked by a fill count, so slots at or above
// it read as zero: reset and clear take effect at once, with no clearing pass over
// the memory.
`default_nettype none
module branch_target_hit_merge_table_top #(
   parameter int TABLE_SLOTS = bthm_pkg::TABLE_SLOTS
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_ready,
   input  wire logic [bthm_pkg::KIND_W-1:0]     req_kind,
   input  wire logic [bthm_pkg::KEY_W-1:0]      req_target_key,
   input  wire logic [bthm_pkg::ADDR_W-1:0]     req_source_addr,
   input  wire logic [bthm_pkg::STACK_W-1:0]    req_stack_index,
   input  wire logic [bthm_pkg::ADDR_W-1:0]     req_site_addr,
   input  wire logic [bthm_pkg::COUNT_W-1:0]    req_hit_count,
   input  wire logic [bthm_pkg::SLOT_W-1:0]     req_read_slot,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_ready,
   output logic [bthm_pkg::STATUS_W-1:0]        rsp_status,
   output logic [bthm_pkg::SLOT_W-1:0]          rsp_slot,
   output logic [bthm_pkg::KEY_W-1:0]           rsp_out_key,
   output logic [bthm_pkg::ADDR_W-1:0]          rsp_out_source,
   output logic [bthm_pkg::STACK_W-1:0]         rsp_out_stack_index,
   output logic [bthm_pkg::ADDR_W-1:0]          rsp_out_site,
   output logic [bthm_pkg::COUNT_W-1:0]         rsp_out_count
);

   localparam int IDX_W = $clog2(TABLE_SLOTS);

   logic                    ram_rd_en;
   logic [IDX_W-1:0]        ram_rd_addr;
   bthm_pkg::entry_type     ram_rd_data;
   logic                    ram_wr_en;
   logic [IDX_W-1:0]        ram_wr_addr;
   bthm_pkg::entry_type     ram_wr_data;
   bthm_pkg::match_req_type mt_req;
   bthm_pkg::match_rsp_type mt_rsp;
   bthm_pkg::entry_type     rsp_entry;

   bthm_sequencer #(
      .TABLE_SLOTS(TABLE_SLOTS)
   ) u_seq (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_kind        (req_kind),
      .req_target_key  (req_target_key),
      .req_source_addr (req_source_addr),
      .req_stack_index (req_stack_index),
      .req_site_addr   (req_site_addr),
      .req_hit_count   (req_hit_count),
      .req_read_slot   (req_read_slot),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_status      (rsp_status),
      .rsp_slot        (rsp_slot),
      .rsp_entry       (rsp_entry),
      .ram_rd_en       (ram_rd_en),
      .ram_rd_addr     (ram_rd_addr),
      .ram_rd_data     (ram_rd_data),
      .ram_wr_en       (ram_wr_en),
      .ram_wr_addr     (ram_wr_addr),
      .ram_wr_data     (ram_wr_data),
      .mt_req          (mt_req),
      .mt_rsp          (mt_rsp)
   );

   bthm_match_unit u_match (
      .mt_req (mt_req),
      .mt_rsp (mt_rsp)
   );

   bthm_table_ram #(
      .TABLE_SLOTS(TABLE_SLOTS)
   ) u_ram (
      .clock   (clock),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data)
   );

   assign rsp_out_key         = rsp_entry.key;
   assign rsp_out_source      = rsp_entry.source;
   assign rsp_out_stack_index = rsp_entry.stack;
   assign rsp_out_site        = rsp_entry.site;
   assign rsp_out_count       = rsp_entry.count;

endmodule
`default_nettype wire

### dv/bthm_checker.sv
// predictor and result checker for the branch target hit merge table
module bthm_checker
   import bthm_pkg::*;
#(
   parameter int TABLE_SLOTS = bthm_pkg::TABLE_SLOTS
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   input  wire logic                req_ready,
   input  wire logic [KIND_W-1:0]   req_kind,
   input  wire logic [KEY_W-1:0]    req_target_key,
   input  wire logic [ADDR_W-1:0]   req_source_addr,
   input  wire logic [STACK_W-1:0]  req_stack_index,
   input  wire logic [ADDR_W-1:0]   req_site_addr,
   input  wire logic [COUNT_W-1:0]  req_hit_count,
   input  wire logic [SLOT_W-1:0]   req_read_slot,
   input  wire logic                rsp_valid,
   input  wire logic                rsp_ready,
   input  wire logic [STATUS_W-1:0] rsp_status,
   input  wire logic [SLOT_W-1:0]   rsp_slot,
   input  wire logic [KEY_W-1:0]    rsp_out_key,
   input  wire logic [ADDR_W-1:0]   rsp_out_source,
   input  wire logic [STACK_W-1:0]  rsp_out_stack_index,
   input  wire logic [ADDR_W-1:0]   rsp_out_site,
   input  wire logic [COUNT_W-1:0]  rsp_out_count,
   output int                       error_count,
   output int                       pending
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [SLOT_W-1:0]   slot;
      entry_type           entry;
   } slot_report_type;

   entry_type       slot_entries [TABLE_SLOTS];
   slot_report_type expected_reports [$];

   function automatic void clear_slots();
      foreach (slot_entries[i]) begin
         slot_entries[i] = '0;
      end
   endfunction

   // updates the table copy and returns the report the block must give
   function automatic slot_report_type apply_request(
      logic [KIND_W-1:0] kind,
      entry_type         item,
      logic [SLOT_W-1:0] read_slot
   );
      slot_report_type rep;
      logic            done;
      int              s;
      rep = '0;
      rep.status = STATUS_DONE;
      done = 1'b0;
      case (kind)
         KIND_MERGE: begin
            if (item.key == '0) begin
               rep.status = STATUS_IGNORED;
            end else begin
               rep.status = STATUS_DROPPED;
               for (s = 0; s < TABLE_SLOTS && !done; s++) begin
                  if (slot_entries[s].key == item.key) begin
                     slot_entries[s].count = slot_entries[s].count + item.count;
                     rep.status = STATUS_ACCUM;
                     done = 1'b1;
                  end else if (slot_entries[s].key == '0) begin
                     slot_entries[s] = item;
                     rep.status = STATUS_INSERT;
                     done = 1'b1;
                  end
                  if (done) begin
                     rep.slot  = SLOT_W'(s);
                     rep.entry = slot_entries[s];
                  end
               end
            end
         end
         KIND_READ: begin
            rep.slot = read_slot;
            if (int'(read_slot) < TABLE_SLOTS) begin
               rep.entry = slot_entries[read_slot];
            end
         end
         KIND_CLEAR: begin
            clear_slots();
         end
         default: begin
         end
      endcase
      return rep;
   endfunction

   task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
         error_count++;
         $display("%0t: %s mismatch, expected %h got %h", $time, name, want, got);
      end
   endtask

   always @(posedge clock) begin
      slot_report_type got;
      slot_report_type want;
      entry_type       item;
      if (reset) begin
         clear_slots();
         expected_reports.delete();
         error_count = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            got.status       = rsp_status;
            got.slot         = rsp_slot;
            got.entry.key    = rsp_out_key;
            got.entry.source = rsp_out_source;
            got.entry.stack  = rsp_out_stack_index;
            got.entry.site   = rsp_out_site;
            got.entry.count  = rsp_out_count;
            if (expected_reports.size() == 0) begin
               error_count++;
               $display("%0t: unexpected result, expected none got %h", $time, got);
            end else begin
               want = expected_reports.pop_front();
               check_field("status", 64'(want.status), 64'(got.status));
               check_field("slot", 64'(want.slot), 64'(got.slot));
               check_field("out_key", want.entry.key, got.entry.key);
               check_field("out_source", want.entry.source, got.entry.source);
               check_field("out_stack_index", 64'(want.entry.stack),
                           64'(got.entry.stack));
               check_field("out_site", want.entry.site, got.entry.site);
               check_field("out_count", 64'(want.entry.count), 64'(got.entry.count));
            end
         end
         if (req_valid && req_ready) begin
            item.key    = req_target_key;
            item.source = req_source_addr;
            item.stack  = req_stack_index;
            item.site   = req_site_addr;
            item.count  = req_hit_count;
            expected_reports.push_back(apply_request(req_kind, item, req_read_slot));
         end
      end
      pending <= expected_reports.size();
   end

endmodule

### dv/testbench.sv
// testbench top: clock, reset, stimulus and verdict for the branch target hit merge table
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import bthm_pkg::*;

   localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
   localparam int CYCLE_LIMIT = 6_000_000;
   localparam int KEY_POOL_SIZE = 32;

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_ready;
   logic [KIND_W-1:0]   req_kind;
   logic [KEY_W-1:0]    req_target_key;
   logic [ADDR_W-1:0]   req_source_addr;
   logic [STACK_W-1:0]  req_stack_index;
   logic [ADDR_W-1:0]   req_site_addr;
   logic [COUNT_W-1:0]  req_hit_count;
   logic [SLOT_W-1:0]   req_read_slot;
   logic                rsp_valid;
   logic                rsp_ready;
   logic [STATUS_W-1:0] rsp_status;
   logic [SLOT_W-1:0]   rsp_slot;
   logic [KEY_W-1:0]    rsp_out_key;
   logic [ADDR_W-1:0]   rsp_out_source;
   logic [STACK_W-1:0]  rsp_out_stack_index;
   logic [ADDR_W-1:0]   rsp_out_site;
   logic [COUNT_W-1:0]  rsp_out_count;

   int error_count;
   int pending;
   int sender_idle_pct;
   int receiver_idle_pct;
   int cycle_count = 0;
   logic [KEY_W-1:0] key_pool [KEY_POOL_SIZE];

   branch_target_hit_merge_table_top u_top (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_kind            (req_kind),
      .req_target_key      (req_target_key),
      .req_source_addr     (req_source_addr),
      .req_stack_index     (req_stack_index),
      .req_site_addr       (req_site_addr),
      .req_hit_count       (req_hit_count),
      .req_read_slot       (req_read_slot),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_status          (rsp_status),
      .rsp_slot            (rsp_slot),
      .rsp_out_key         (rsp_out_key),
      .rsp_out_source      (rsp_out_source),
      .rsp_out_stack_index (rsp_out_stack_index),
      .rsp_out_site        (rsp_out_site),
      .rsp_out_count       (rsp_out_count)
   );

   bthm_checker u_checker (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_kind            (req_kind),
      .req_target_key      (req_target_key),
      .req_source_addr     (req_source_addr),
      .req_stack_index     (req_stack_index),
      .req_site_addr       (req_site_addr),
      .req_hit_count       (req_hit_count),
      .req_read_slot       (req_read_slot),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_status          (rsp_status),
      .rsp_slot            (rsp_slot),
      .rsp_out_key         (rsp_out_key),
      .rsp_out_source      (rsp_out_source),
      .rsp_out_stack_index (rsp_out_stack_index),
      .rsp_out_site        (rsp_out_site),
      .rsp_out_count       (rsp_out_count),
      .error_count         (error_count),
      .pending             (pending)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= receiver_idle_pct);
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   function automatic logic [63:0] rand_word();
      return {$urandom, $urandom};
   endfunction

   // presents one transaction and returns at the edge where it is taken
   task automatic send_request(
      logic [KIND_W-1:0]  kind,
      logic [KEY_W-1:0]   key,
      logic [ADDR_W-1:0]  source,
      logic [STACK_W-1:0] stack,
      logic [ADDR_W-1:0]  site,
      logic [COUNT_W-1:0] hits,
      logic [SLOT_W-1:0]  read_slot
   );
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_kind        <= kind;
      req_target_key  <= key;
      req_source_addr <= source;
      req_stack_index <= stack;
      req_site_addr   <= site;
      req_hit_count   <= hits;
      req_read_slot   <= read_slot;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) begin
         @(posedge clock);
      end
   endtask

   task automatic run_random_phase(int items, int send_pct, int recv_pct);
      logic [KIND_W-1:0]  kind;
      logic [KEY_W-1:0]   key;
      logic [COUNT_W-1:0] hits;
      logic [SLOT_W-1:0]  read_slot;
      int                 pick;
      sender_idle_pct   = send_pct;
      receiver_idle_pct = recv_pct;
      repeat (items) begin
         pick = $urandom_range(99);
         if (pick < 3) begin
            kind = KIND_CLEAR;
         end else if (pick < 5) begin
            kind = KIND_UNUSED;
         end else if (pick < 20) begin
            kind = KIND_READ;
         end else begin
            kind = KIND_MERGE;
         end
         pick = $urandom_range(99);
         if (pick < 4) begin
            key = '0;
         end else if (pick < 80) begin
            key = key_pool[$urandom_range(KEY_POOL_SIZE-1)];
         end else begin
            key = rand_word();
         end
         hits = ($urandom_range(3) == 0) ? COUNT_W'($urandom_range(15)) : $urandom;
         read_slot = ($urandom_range(9) < 8) ? SLOT_W'($urandom_range(47))
                                             : SLOT_W'($urandom_range(1023));
         send_request(kind, key, rand_word(), STACK_W'($urandom), rand_word(),
                      hits, read_slot);
      end
   endtask

   initial begin
      reset             = 1'b1;
      req_valid         = 1'b0;
      req_kind          = KIND_MERGE;
      req_target_key    = '0;
      req_source_addr   = '0;
      req_stack_index   = '0;
      req_site_addr     = '0;
      req_hit_count     = '0;
      req_read_slot     = '0;
      rsp_ready         = 1'b0;
      sender_idle_pct   = 0;
      receiver_idle_pct = 0;
      foreach (key_pool[i]) begin
         do key_pool[i] = rand_word(); while (key_pool[i] == '0);
      end
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // directed corners
      send_request(KIND_MERGE, '0, '1, '1, '1, '1, '1);
      send_request(KIND_READ, '0, '0, '0, '0, '0, '0);
      send_request(KIND_MERGE, '1, '1, '1, '1, '1, '0);
      send_request(KIND_MERGE, '1, '0, '0, '0, 32'd1, '0);
      send_request(KIND_MERGE, 64'd1, '0, '0, '0, '0, '0);
      send_request(KIND_MERGE, 64'h8000_0000_0000_0000, 64'h5555_5555_5555_5555,
                   5'h15, 64'hAAAA_AAAA_AAAA_AAAA, 32'h8000_0000, '0);
      send_request(KIND_MERGE, '1, '0, '0, '0, '1, '0);
      send_request(KIND_READ, '0, '0, '0, '0, '0, 10'd0);
      send_request(KIND_READ, '0, '0, '0, '0, '0, 10'd1);
      send_request(KIND_READ, '0, '0, '0, '0, '0, 10'd2);
      send_request(KIND_READ, '1, '1, '1, '1, '1, '1);
      send_request(KIND_UNUSED, '1, '1, '1, '1, '1, 10'd1);
      send_request(KIND_CLEAR, '1, '1, '1, '1, '1, 10'd1);
      send_request(KIND_READ, '0, '0, '0, '0, '0, 10'd0);
      send_request(KIND_MERGE, 64'd1, 64'h0123_4567_89AB_CDEF, 5'h0A,
                   64'hFEDC_BA98_7654_3210, 32'h0000_FFFF, '0);
      send_request(KIND_READ, '0, '0, '0, '0, '0, 10'd1);
      send_request(KIND_CLEAR, '0, '0, '0, '0, '0, '0);
      drain_results();

      run_random_phase(195, 23, 70);
      drain_results();
      run_random_phase(195, 70, 23);
      drain_results();
      run_random_phase(190, 0, 0);
      drain_results();
      repeat (20) @(posedge clock);

      if (error_count == 0 && pending == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
